@@ rtl/dnhcc_pkg.sv @@
// dnhcc_pkg: types, field widths, reset values and register indexes
// for the day/night hysteresis climate controller.
// Depends on nothing; every other rtl file imports it.
`default_nettype none

package dnhcc_pkg;

	// input word fields
	localparam int MINUTE_W = 11;
	localparam int DAY_W    = 5;
	localparam int TEMP_W   = 12;
	localparam int HUM_W    = 10;
	localparam int IN_W     = MINUTE_W + DAY_W + TEMP_W + HUM_W;
	localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

	// statistics
	localparam int COUNT_WIDTH = 16;
	localparam int CNT_FIELD_W = 16;
	localparam int SUM_W       = 28;
	localparam logic signed [TEMP_W-1:0] MIN_RESET = TEMP_W'(400);
	localparam logic signed [SUM_W-1:0]  SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0]  SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

	// result word: light, fan, then per period max, min, sum, count
	localparam int PERIOD_W    = 2 * TEMP_W + SUM_W + CNT_FIELD_W;
	localparam int OUT_W       = 2 + 2 * PERIOD_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// configuration
	localparam int SP_W     = 8;
	localparam int LIM_W    = 7;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 3;

	localparam logic [SP_W-1:0]     DAY_SP_RST     = 8'd25;
	localparam logic [SP_W-1:0]     NIGHT_SP_RST   = 8'd20;
	localparam logic [SP_W-1:0]     DAY_HY_RST     = 8'd2;
	localparam logic [SP_W-1:0]     NIGHT_HY_RST   = 8'd2;
	localparam logic [LIM_W-1:0]    DAY_LIM_RST    = 7'd70;
	localparam logic [LIM_W-1:0]    NIGHT_LIM_RST  = 7'd70;
	localparam logic [MINUTE_W-1:0] LIGHT_START_RST = 11'd480;
	localparam logic [MINUTE_W-1:0] LIGHT_END_RST   = 11'd1200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DAY_SETPOINT     = 3'd0,
		REG_NIGHT_SETPOINT   = 3'd1,
		REG_DAY_HYSTERESIS   = 3'd2,
		REG_NIGHT_HYSTERESIS = 3'd3,
		REG_DAY_HUM_LIMIT    = 3'd4,
		REG_NIGHT_HUM_LIMIT  = 3'd5,
		REG_LIGHT_START      = 3'd6,
		REG_LIGHT_END        = 3'd7
	} cfg_reg_t;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QFILL_W = $clog2(QDEPTH + 1);

	// classified tick as handed from front to back
	typedef struct packed {
		logic                     light;
		logic                     hot;    // above setpoint plus band
		logic                     humid;  // above humidity limit
		logic                     cold;   // below setpoint minus band
		logic [DAY_W-1:0]         day;
		logic signed [TEMP_W-1:0] temp;
	} item_t;

endpackage

`default_nettype wire

@@ rtl/day_night_hysteresis_climate_control.sv @@
// day_night_hysteresis_climate_control: top level of the climate controller,
// joining front, queue and back. Depends on dnhcc_pkg, dnhcc_front,
// dnhcc_queue and dnhcc_back.
//
// Use:
//   Tick words arrive on the s_ group (minute of day, day of month,
//   temperature and humidity in tenths). For each word one result word
//   leaves on the m_ group: light and fan drive, and the day and night
//   maximum, minimum, sum and count of temperature since the day changed.
//   Settings are written through cfg_wen/cfg_idx/cfg_wdata, one register
//   per cycle, while no tick is in flight.
// Timing:
//   The front classifies a word in the cycle it is accepted and places it in
//   a two-entry queue; the back pops it when its result register is free
//   or being taken, and updates its state, which is the result register.
//   A word passes the queue slot, then that register, before valid rises.
//   Throughput is one word per cycle while m_tready stays high.
// Reset:
//   arst_n restores the default setpoints, bands, humidity limits and light
//   window, turns the fan off and clears statistics (minimum to 40.0 C).
// Stall:
//   While m_tready is low the result holds and the queue fills; s_tready
//   drops once both queue entries are taken, so no word is lost.
`default_nettype none

module day_night_hysteresis_climate_control (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              cfg_wen,
	input  wire logic [dnhcc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [dnhcc_pkg::CFG_W-1:0]       cfg_wdata,
	// tick words in
	input  wire logic                              s_tvalid,
	output      logic                              s_tready,
	// from bit 0: minute_of_day[10:0], day_of_month[4:0], temperature[11:0],
	// humidity[9:0], zero fill
	input  wire logic [dnhcc_pkg::IN_TDATA_W-1:0]  s_tdata,
	// result words out
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	// from bit 0: light_on, fan_on, day_max[11:0], day_min[11:0],
	// day_sum[27:0], day_count[15:0], night_max[11:0], night_min[11:0],
	// night_sum[27:0], night_count[15:0], zero fill
	output      logic [dnhcc_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import dnhcc_pkg::*;

	logic  push, q_ready, q_valid, pop;
	item_t push_item, q_item;

	// classify each word as it arrives
	dnhcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_data   (s_tdata),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready)
	);

	// hold classified words while the back is stalled
	dnhcc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_item  (push_item),
		.wr_ready (q_ready),
		.rd_en    (pop),
		.rd_valid (q_valid),
		.rd_item  (q_item)
	);

	// advance fan state and statistics, present the result
	dnhcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_ready (m_tready)
	);

	assign s_tready = q_ready;

endmodule

`default_nettype wire

@@ rtl/dnhcc_front.sv @@
// dnhcc_front: configuration registers and classification of tick words
// (light window, fan thresholds). Depends on dnhcc_pkg.
`default_nettype none

module dnhcc_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wen,
	input  wire logic [dnhcc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [dnhcc_pkg::CFG_W-1:0]       cfg_wdata,
	input  wire logic                              in_valid,
	input  wire logic [dnhcc_pkg::IN_TDATA_W-1:0]  in_data,
	output      logic                              push,
	output      dnhcc_pkg::item_t                  push_item,
	input  wire logic                              q_ready
);
	import dnhcc_pkg::*;

	logic [SP_W-1:0]     day_sp_q, night_sp_q, day_hy_q, night_hy_q;
	logic [LIM_W-1:0]    day_lim_q, night_lim_q;
	logic [MINUTE_W-1:0] start_q, end_q;

	logic [MINUTE_W-1:0]      minute;
	logic [DAY_W-1:0]         day;
	logic signed [TEMP_W-1:0] temp;
	logic [HUM_W-1:0]         hum;
	logic                     light;
	logic [SP_W-1:0]          sp, hy;
	logic [LIM_W-1:0]         lim;
	logic [SP_W+4:0]          hi_mag;
	logic signed [SP_W+1:0]   lo_diff;
	logic signed [SP_W+5:0]   lo_thr;
	logic [LIM_W+3:0]         hum_thr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_sp_q    <= DAY_SP_RST;
			night_sp_q  <= NIGHT_SP_RST;
			day_hy_q    <= DAY_HY_RST;
			night_hy_q  <= NIGHT_HY_RST;
			day_lim_q   <= DAY_LIM_RST;
			night_lim_q <= NIGHT_LIM_RST;
			start_q     <= LIGHT_START_RST;
			end_q       <= LIGHT_END_RST;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_idx))
				REG_DAY_SETPOINT:     day_sp_q    <= cfg_wdata[SP_W-1:0];
				REG_NIGHT_SETPOINT:   night_sp_q  <= cfg_wdata[SP_W-1:0];
				REG_DAY_HYSTERESIS:   day_hy_q    <= cfg_wdata[SP_W-1:0];
				REG_NIGHT_HYSTERESIS: night_hy_q  <= cfg_wdata[SP_W-1:0];
				REG_DAY_HUM_LIMIT:    day_lim_q   <= cfg_wdata[LIM_W-1:0];
				REG_NIGHT_HUM_LIMIT:  night_lim_q <= cfg_wdata[LIM_W-1:0];
				REG_LIGHT_START:      start_q     <= cfg_wdata[MINUTE_W-1:0];
				REG_LIGHT_END:        end_q       <= cfg_wdata[MINUTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign minute = in_data[MINUTE_W-1:0];
	assign day    = in_data[MINUTE_W +: DAY_W];
	assign temp   = signed'(in_data[MINUTE_W+DAY_W +: TEMP_W]);
	assign hum    = in_data[MINUTE_W+DAY_W+TEMP_W +: HUM_W];

	always_comb begin
		// window wraps past midnight when it starts after it ends
		if (start_q > end_q) begin
			light = (minute >= start_q) || (minute <= end_q);
		end else begin
			light = (minute >= start_q) && (minute <= end_q);
		end
		sp  = light ? day_sp_q  : night_sp_q;
		hy  = light ? day_hy_q  : night_hy_q;
		lim = light ? day_lim_q : night_lim_q;

		hi_mag  = ({5'b0, sp} + {5'b0, hy}) * (SP_W+5)'(10);
		lo_diff = signed'({2'b00, sp}) - signed'({2'b00, hy});
		lo_thr  = (SP_W+6)'(lo_diff * (SP_W+6)'(10));
		hum_thr = {4'b0, lim} * (LIM_W+4)'(10);

		push_item.light = light;
		push_item.hot   = temp > signed'({1'b0, hi_mag});
		push_item.humid = (LIM_W+4)'(hum) > hum_thr;
		push_item.cold  = temp < lo_thr;
		push_item.day   = day;
		push_item.temp  = temp;
	end

	assign push = in_valid && q_ready;

endmodule

`default_nettype wire

@@ rtl/dnhcc_queue.sv @@
// dnhcc_queue: short register queue of classified ticks between the
// front and the back. Depends on dnhcc_pkg.
`default_nettype none

module dnhcc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire dnhcc_pkg::item_t wr_item,
	output      logic             wr_ready,
	input  wire logic             rd_en,
	output      logic             rd_valid,
	output      dnhcc_pkg::item_t rd_item
);
	import dnhcc_pkg::*;

	item_t               slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QFILL_W-1:0]  fill_q;
	logic                do_wr, do_rd;

	assign wr_ready = fill_q != QFILL_W'(QDEPTH);
	assign rd_valid = fill_q != '0;
	assign rd_item  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && wr_ready;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= QFILL_W'(QDEPTH))
		else $error("queue fill beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

@@ rtl/dnhcc_back.sv @@
// dnhcc_back: fan hysteresis state, per period statistics and the result
// register. Depends on dnhcc_pkg.
`default_nettype none

module dnhcc_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              q_valid,
	input  wire dnhcc_pkg::item_t                  q_item,
	output      logic                              pop,
	output      logic                              out_valid,
	output      logic [dnhcc_pkg::OUT_TDATA_W-1:0] out_data,
	input  wire logic                              out_ready
);
	import dnhcc_pkg::*;

	logic                     valid_q, light_q, fan_q;
	logic [DAY_W-1:0]         last_day_q;
	logic signed [TEMP_W-1:0] max_q [2];
	logic signed [TEMP_W-1:0] min_q [2];
	logic signed [SUM_W-1:0]  sum_q [2];
	logic [COUNT_WIDTH-1:0]   cnt_q [2];

	logic                     sel;
	logic                     new_day;
	logic signed [SUM_W:0]    sum_wide;
	logic signed [SUM_W-1:0]  sum_sat;

	// result register is the state itself: it only moves on a pop
	assign pop     = q_valid && (!valid_q || out_ready);
	assign sel     = !q_item.light;
	assign new_day = q_item.day != last_day_q;

	always_comb begin
		sum_wide = (SUM_W+1)'(sum_q[sel]) + (SUM_W+1)'(q_item.temp);
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			light_q    <= 1'b0;
			fan_q      <= 1'b0;
			last_day_q <= '0;
			for (int p = 0; p < 2; p++) begin
				max_q[p] <= '0;
				min_q[p] <= MIN_RESET;
				sum_q[p] <= '0;
				cnt_q[p] <= '0;
			end
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				light_q <= q_item.light;
				if (q_item.hot || q_item.humid) begin
					fan_q <= 1'b1;
				end else if (q_item.cold) begin
					fan_q <= 1'b0;
				end
				last_day_q <= q_item.day;
				for (int p = 0; p < 2; p++) begin
					if (new_day) begin
						max_q[p] <= '0;
						min_q[p] <= MIN_RESET;
						sum_q[p] <= '0;
						cnt_q[p] <= '0;
					end else if (sel == 1'(p)) begin
						sum_q[p] <= sum_sat;
						if (cnt_q[p] != '1) begin
							cnt_q[p] <= cnt_q[p] + 1'b1;
						end
						if (q_item.temp > max_q[p]) begin
							max_q[p] <= q_item.temp;
						end
						if (q_item.temp < min_q[p]) begin
							min_q[p] <= q_item.temp;
						end
					end
				end
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = OUT_TDATA_W'({
		CNT_FIELD_W'(cnt_q[1]), sum_q[1], min_q[1], max_q[1],
		CNT_FIELD_W'(cnt_q[0]), sum_q[0], min_q[0], max_q[0],
		fan_q, light_q});

	a_day_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && new_day) |=> (cnt_q[0] == '0 && cnt_q[1] == '0 &&
			sum_q[0] == '0 && sum_q[1] == '0))
		else $error("statistics not cleared on day change");

	a_fan_on: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (q_item.hot || q_item.humid)) |=> fan_q)
		else $error("fan not driven above band");

	a_fan_off: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !q_item.hot && !q_item.humid && q_item.cold) |=> !fan_q)
		else $error("fan not released below band");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> ($stable(fan_q) && $stable(last_day_q)))
		else $error("state moved without a tick");

endmodule

`default_nettype wire

@@ dv/climate_watch.sv @@
// climate_watch: monitor, predictor and checker for the climate controller.
// Watches the settings port and both word streams; depends on dnhcc_pkg.
// Reports the running fault count and the number of results still due.
module climate_watch import dnhcc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [CFG_W-1:0]       cfg_wdata,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	// from bit 0: minute_of_day, day_of_month, temperature, humidity, zero fill
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	// from bit 0: light_on, fan_on, day max/min/sum/count, night max/min/sum/count
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,
	output int                          fault_count,
	output int                          words_in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [IN_TDATA_W-IN_W-1:0] fill;
		logic [HUM_W-1:0]           humidity;
		logic signed [TEMP_W-1:0]   temperature;
		logic [DAY_W-1:0]           day;
		logic [MINUTE_W-1:0]        minute;
	} tick_t;

	typedef struct packed {
		logic [OUT_TDATA_W-OUT_W-1:0] fill;
		logic [CNT_FIELD_W-1:0]       night_count;
		logic signed [SUM_W-1:0]      night_sum;
		logic signed [TEMP_W-1:0]     night_min;
		logic signed [TEMP_W-1:0]     night_max;
		logic [CNT_FIELD_W-1:0]       day_count;
		logic signed [SUM_W-1:0]      day_sum;
		logic signed [TEMP_W-1:0]     day_min;
		logic signed [TEMP_W-1:0]     day_max;
		logic                         fan_on;
		logic                         light_on;
	} climate_status_t;

	// settings as the block holds them, already cut to register width
	logic [CFG_W-1:0]         settings [8];
	logic                     fan_state;
	logic [DAY_W-1:0]         last_day;
	// per period statistics, index 0 day, 1 night
	logic signed [TEMP_W-1:0] peak [2];
	logic signed [TEMP_W-1:0] trough [2];
	logic signed [SUM_W-1:0]  total [2];
	logic [COUNT_WIDTH-1:0]   tally [2];

	climate_status_t awaited_status [$];
	int faults = 0;

	assign fault_count = faults;

	function automatic void clear_statistics();
		for (int p = 0; p < 2; p++) begin
			peak[p]   = '0;
			trough[p] = MIN_RESET;
			total[p]  = '0;
			tally[p]  = '0;
		end
	endfunction

	function automatic climate_status_t step_climate(input logic [IN_TDATA_W-1:0] word);
		tick_t                tick;
		logic [MINUTE_W-1:0]  start;
		logic [MINUTE_W-1:0]  stop;
		logic                 light;
		int                   p;
		int                   sp;
		int                   hy;
		int                   lim;
		longint               acc;
		climate_status_t      r;
		tick  = tick_t'(word);
		start = settings[REG_LIGHT_START][MINUTE_W-1:0];
		stop  = settings[REG_LIGHT_END][MINUTE_W-1:0];
		// a window whose start lies after its end wraps past midnight
		if (start > stop)
			light = (tick.minute >= start) || (tick.minute <= stop);
		else
			light = (tick.minute >= start) && (tick.minute <= stop);
		p   = light ? 0 : 1;
		sp  = int'(settings[light ? REG_DAY_SETPOINT : REG_NIGHT_SETPOINT]);
		hy  = int'(settings[light ? REG_DAY_HYSTERESIS : REG_NIGHT_HYSTERESIS]);
		lim = int'(settings[light ? REG_DAY_HUM_LIMIT : REG_NIGHT_HUM_LIMIT]);

		if (int'(tick.temperature) > (sp + hy) * 10 || int'(tick.humidity) > lim * 10)
			fan_state = 1'b1;
		else if (int'(tick.temperature) < (sp - hy) * 10)
			fan_state = 1'b0;

		acc = longint'(total[p]) + longint'(tick.temperature);
		if (acc > longint'(SUM_MAX))
			acc = longint'(SUM_MAX);
		if (acc < longint'(SUM_MIN))
			acc = longint'(SUM_MIN);
		total[p] = SUM_W'(acc);
		if (tally[p] != {COUNT_WIDTH{1'b1}})
			tally[p] = tally[p] + 1'b1;
		if (tick.temperature > peak[p])
			peak[p] = tick.temperature;
		if (tick.temperature < trough[p])
			trough[p] = tick.temperature;

		// sample lands first, then a new day wipes everything
		if (tick.day != last_day) begin
			clear_statistics();
			last_day = tick.day;
		end

		r             = '0;
		r.light_on    = light;
		r.fan_on      = fan_state;
		r.day_max     = peak[0];
		r.day_min     = trough[0];
		r.day_sum     = total[0];
		r.day_count   = CNT_FIELD_W'(tally[0]);
		r.night_max   = peak[1];
		r.night_min   = trough[1];
		r.night_sum   = total[1];
		r.night_count = CNT_FIELD_W'(tally[1]);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			faults++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		climate_status_t want;
		climate_status_t got;
		if (!arst_n) begin
			settings[REG_DAY_SETPOINT]     = CFG_W'(DAY_SP_RST);
			settings[REG_NIGHT_SETPOINT]   = CFG_W'(NIGHT_SP_RST);
			settings[REG_DAY_HYSTERESIS]   = CFG_W'(DAY_HY_RST);
			settings[REG_NIGHT_HYSTERESIS] = CFG_W'(NIGHT_HY_RST);
			settings[REG_DAY_HUM_LIMIT]    = CFG_W'(DAY_LIM_RST);
			settings[REG_NIGHT_HUM_LIMIT]  = CFG_W'(NIGHT_LIM_RST);
			settings[REG_LIGHT_START]      = CFG_W'(LIGHT_START_RST);
			settings[REG_LIGHT_END]        = CFG_W'(LIGHT_END_RST);
			fan_state = 1'b0;
			last_day  = '0;
			clear_statistics();
			awaited_status.delete();
		end else begin
			if (cfg_wen) begin
				case (cfg_reg_t'(cfg_idx))
					REG_DAY_HUM_LIMIT, REG_NIGHT_HUM_LIMIT:
						settings[cfg_idx] = CFG_W'(cfg_wdata[LIM_W-1:0]);
					REG_LIGHT_START, REG_LIGHT_END:
						settings[cfg_idx] = cfg_wdata;
					default:
						settings[cfg_idx] = CFG_W'(cfg_wdata[SP_W-1:0]);
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (awaited_status.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, m_tdata);
					faults++;
				end else begin
					want = awaited_status.pop_front();
					got  = climate_status_t'(m_tdata);
					check_field("light_on", want.light_on, got.light_on);
					check_field("fan_on", want.fan_on, got.fan_on);
					check_field("day_max", want.day_max, got.day_max);
					check_field("day_min", want.day_min, got.day_min);
					check_field("day_sum", want.day_sum, got.day_sum);
					check_field("day_count", want.day_count, got.day_count);
					check_field("night_max", want.night_max, got.night_max);
					check_field("night_min", want.night_min, got.night_min);
					check_field("night_sum", want.night_sum, got.night_sum);
					check_field("night_count", want.night_count, got.night_count);
					check_field("fill", want.fill, got.fill);
				end
			end
			if (s_tvalid && s_tready)
				awaited_status.push_back(step_climate(s_tdata));
		end
		words_in_flight = awaited_status.size();
	end

endmodule

@@ dv/tb_day_night_hysteresis_climate_control.sv @@
// tb_day_night_hysteresis_climate_control: stimulus and verdict for the
// climate controller. Depends on dnhcc_pkg, the block and climate_watch.
module tb_day_night_hysteresis_climate_control;
	import dnhcc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// receiver hold-off long enough to fill the two-entry queue and stall input
	localparam int HOLD_CYCLES = 48;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 150;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wen;
	cfg_reg_t               cfg_idx;
	logic [CFG_W-1:0]       cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	int                     fault_count;
	int                     words_in_flight;

	// settings to be programmed by apply_plan, also used to aim temperatures at band edges
	logic [CFG_W-1:0] plan [8];
	int  sender_gap_pct = 20;
	int  sink_gap_pct   = 20;
	bit  hold_request   = 1'b0;
	// wall clock carried by well-formed ticks
	int  clock_minute   = 0;
	int  today          = 1;

	always #10 clk = ~clk;

	day_night_hysteresis_climate_control dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	climate_watch watch (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.fault_count     (fault_count),
		.words_in_flight (words_in_flight)
	);

	// mostly short gaps, now and then a long one
	function automatic int gap_cycles();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(1, 3);
	endfunction

	// pack a tick word, minute in the lowest bits, zero fill on top
	function automatic logic [IN_TDATA_W-1:0] pack_tick(input int minute, input int day,
			input int temp, input int hum);
		return {{(IN_TDATA_W-IN_W){1'b0}}, HUM_W'(hum), TEMP_W'(temp), DAY_W'(day),
			MINUTE_W'(minute)};
	endfunction

	// Well-formed ticks walk the clock forward and roll the day now and then,
	// so the statistics build up; a share of raw noise covers every bit.
	function automatic logic [IN_TDATA_W-1:0] random_tick();
		int band_sp;
		int band_hy;
		int limit;
		int temp;
		int hum;
		bit day_edge;
		if ($urandom_range(0, 99) < 12)
			return pack_tick($urandom, $urandom, $urandom, $urandom);
		clock_minute += $urandom_range(1, 45);
		if (clock_minute >= 1440) begin
			clock_minute -= 1440;
			today = (today >= 31) ? 1 : today + 1;
		end
		if ($urandom_range(0, 99) < 2)
			today = $urandom_range(1, 31);
		day_edge = $urandom_range(0, 1);
		band_sp  = int'(plan[day_edge ? REG_DAY_SETPOINT : REG_NIGHT_SETPOINT][SP_W-1:0]);
		band_hy  = int'(plan[day_edge ? REG_DAY_HYSTERESIS : REG_NIGHT_HYSTERESIS][SP_W-1:0]);
		limit    = int'(plan[day_edge ? REG_DAY_HUM_LIMIT : REG_NIGHT_HUM_LIMIT][LIM_W-1:0]);
		// aim at either edge of the band, including the exact edge, or anywhere in range
		case ($urandom_range(0, 3))
			0: temp = (band_sp + band_hy) * 10 + int'($urandom_range(0, 4)) - 2;
			1: temp = (band_sp - band_hy) * 10 + int'($urandom_range(0, 4)) - 2;
			default: temp = int'($urandom_range(0, 1650)) - 400;
		endcase
		if ($urandom_range(0, 3) == 0)
			hum = limit * 10 + int'($urandom_range(0, 2)) - 1;
		else
			hum = $urandom_range(0, 1000);
		return pack_tick(clock_minute, today, temp, hum);
	endfunction

	// Offer one word, maybe after a gap, and hold it until taken.
	// Leaves at the falling edge after the handshake with valid still high.
	task automatic offer_tick(input logic [IN_TDATA_W-1:0] word);
		if ($urandom_range(0, 99) < sender_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat (gap_cycles()) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (s_tready !== 1'b1);
		@(negedge clk);
	endtask

	// Drop valid and wait until every result has come back.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		wait (words_in_flight == 0);
		@(negedge clk);
	endtask

	// Write every register from the plan, one per cycle, idle block only.
	task automatic apply_plan();
		cfg_reg_t r;
		r = r.first();
		do begin
			cfg_wen   <= 1'b1;
			cfg_idx   <= r;
			cfg_wdata <= plan[r];
			@(negedge clk);
			r = r.next();
		end while (r != r.first());
		cfg_wen <= 1'b0;
	endtask

	task automatic plan_defaults();
		plan[REG_DAY_SETPOINT]     = CFG_W'(DAY_SP_RST);
		plan[REG_NIGHT_SETPOINT]   = CFG_W'(NIGHT_SP_RST);
		plan[REG_DAY_HYSTERESIS]   = CFG_W'(DAY_HY_RST);
		plan[REG_NIGHT_HYSTERESIS] = CFG_W'(NIGHT_HY_RST);
		plan[REG_DAY_HUM_LIMIT]    = CFG_W'(DAY_LIM_RST);
		plan[REG_NIGHT_HUM_LIMIT]  = CFG_W'(NIGHT_LIM_RST);
		plan[REG_LIGHT_START]      = CFG_W'(LIGHT_START_RST);
		plan[REG_LIGHT_END]        = CFG_W'(LIGHT_END_RST);
	endtask

	// Receiver: random stalls, or a long hold-off when the stimulus asks for one.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				m_tready <= 1'b1;
			end else if ($urandom_range(0, 99) < sink_gap_pct) begin
				m_tready <= 1'b0;
				repeat (gap_cycles()) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin
		int saved_gap;
		arst_n    = 1'b0;
		cfg_wen   = 1'b0;
		cfg_idx   = REG_DAY_SETPOINT;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		plan_defaults();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed ticks at reset settings: day band 230..270, night 180..220,
		// humidity limit 700, light 480..1200.
		// day stays zero first, so no clearing on the opening tick
		offer_tick(pack_tick(0, 0, 0, 0));
		// window edges, with the band edges hit exactly or just passed
		offer_tick(pack_tick(480, 0, 271, 0));
		offer_tick(pack_tick(1200, 0, 230, 0));
		offer_tick(pack_tick(1201, 0, 179, 0));
		offer_tick(pack_tick(479, 0, 220, 0));
		// humidity forces the fan; equal to the limit does not
		offer_tick(pack_tick(479, 0, 200, 701));
		offer_tick(pack_tick(700, 0, 250, 700));
		// temperature and humidity at the extremes of their bits
		offer_tick(pack_tick(700, 0, -2048, 0));
		offer_tick(pack_tick(700, 0, 2047, 1023));
		// minutes beyond the day still compare as plain numbers
		offer_tick(pack_tick(2047, 0, -400, 1000));
		offer_tick(pack_tick(1439, 0, 1250, 0));
		// day change clears, then a sample just above the minimum's reset
		offer_tick(pack_tick(0, 1, 100, 0));
		offer_tick(pack_tick(600, 1, 401, 0));
		offer_tick(pack_tick(600, 1, 400, 0));
		offer_tick(pack_tick(600, 1, -1, 0));
		offer_tick(pack_tick(1440, 31, 0, 500));
		offer_tick(pack_tick(800, 31, -401, 999));
		offer_tick(pack_tick(800, 31, 0, 0));

		for (int phase = 0; phase < PHASES; phase++) begin
			// sender pauses here until every result is back
			settle();
			case (phase)
				0: foreach (plan[i]) plan[i] = '0;
				// all ones: registers keep only their own width
				1: foreach (plan[i]) plan[i] = '1;
				2: begin
					// light window wrapping past midnight
					plan[REG_DAY_SETPOINT]     = 22;
					plan[REG_NIGHT_SETPOINT]   = 18;
					plan[REG_DAY_HYSTERESIS]   = 1;
					plan[REG_NIGHT_HYSTERESIS] = 3;
					plan[REG_DAY_HUM_LIMIT]    = 60;
					plan[REG_NIGHT_HUM_LIMIT]  = 85;
					plan[REG_LIGHT_START]      = 1320;
					plan[REG_LIGHT_END]        = 360;
				end
				3: begin
					// a one-minute light window
					plan_defaults();
					plan[REG_LIGHT_START] = 720;
					plan[REG_LIGHT_END]   = 720;
				end
				7: foreach (plan[i]) plan[i] = CFG_W'($urandom);
				default: begin
					plan[REG_DAY_SETPOINT]     = $urandom_range(10, 35);
					plan[REG_NIGHT_SETPOINT]   = $urandom_range(10, 35);
					plan[REG_DAY_HYSTERESIS]   = $urandom_range(0, 5);
					plan[REG_NIGHT_HYSTERESIS] = $urandom_range(0, 5);
					plan[REG_DAY_HUM_LIMIT]    = $urandom_range(30, 100);
					plan[REG_NIGHT_HUM_LIMIT]  = $urandom_range(30, 100);
					plan[REG_LIGHT_START]      = $urandom_range(0, 1439);
					plan[REG_LIGHT_END]        = $urandom_range(0, 1439);
				end
			endcase
			apply_plan();
			// one phase runs flat out on both sides
			sender_gap_pct = (phase == 5) ? 0 : 30;
			sink_gap_pct   = (phase == 5) ? 0 : 30;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (phase == 2 && i == 60) begin
					// hold the receiver off and keep offering, so input stalls
					saved_gap      = sender_gap_pct;
					sender_gap_pct = 0;
					hold_request   = 1'b1;
					repeat (12) offer_tick(random_tick());
					sender_gap_pct = saved_gap;
				end
				offer_tick(random_tick());
			end
		end

		settle();
		// let the pipeline drain
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("tb_day_night_hysteresis_climate_control OK");
		else
			$display("tb_day_night_hysteresis_climate_control NOT OK");
		$finish;
	end

	// Timeout well beyond the slowest correct run
	initial begin
		#18_000_000;
		$display("tb_day_night_hysteresis_climate_control NOT OK");
		$finish;
	end

endmodule

@@ day_night_hysteresis_climate_control.f @@
rtl/dnhcc_pkg.sv
rtl/dnhcc_front.sv
rtl/dnhcc_queue.sv
rtl/dnhcc_back.sv
rtl/day_night_hysteresis_climate_control.sv
dv/climate_watch.sv
dv/tb_day_night_hysteresis_climate_control.sv
